FILE: sv/brp_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the binary record packer.
// No dependencies; every other file of the block imports this package.
package brp_pkg;

  localparam logic [3:0] FUNC_BEGIN  = 4'd0;
  localparam logic [3:0] FUNC_FLAG   = 4'd1;
  localparam logic [3:0] FUNC_INT8   = 4'd2;
  localparam logic [3:0] FUNC_INT16  = 4'd3;
  localparam logic [3:0] FUNC_INT24  = 4'd4;
  localparam logic [3:0] FUNC_INT32  = 4'd5;
  localparam logic [3:0] FUNC_INT64  = 4'd6;
  localparam logic [3:0] FUNC_REAL16 = 4'd7;
  localparam logic [3:0] FUNC_REAL32 = 4'd8;
  localparam logic [3:0] FUNC_REAL64 = 4'd9;
  localparam logic [3:0] FUNC_END    = 4'd10;

  localparam logic REG_CAPACITY   = 1'b0;
  localparam logic REG_FLAG_BYTES = 1'b1;

  typedef struct packed {
    logic [3:0]  func;
    logic [63:0] value;
  } brp_req_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  byte_value;
    logic [7:0]  byte_index;
    logic [7:0]  record_length;
    logic        success;
    logic        last;
  } brp_res_t;

  typedef enum logic [1:0] {
    OP_BEGIN,
    OP_FLAG,
    OP_BYTES,
    OP_END
  } brp_op_t;

  typedef struct packed {
    brp_op_t     op;
    logic [3:0]  nbytes;
    logic [63:0] data;
  } brp_cmd_t;

  typedef struct packed {
    logic [7:0] capacity;
    logic [3:0] flag_bytes;
  } brp_cfg_t;

endpackage

FILE: sv/binary_record_packer_unit.sv
`timescale 1ns / 1ps
// Binary record packer: a request passes through the command queue, the serializer's command
// register and the result register before its first result is offered. Throughput is set by
// the serializer, which emits one byte per cycle while the output is not stalled.
// A four-entry command queue lets requests arrive while bytes are still leaving.
// Synchronous reset clears the queue, the record state and the output; registers return
// to capacity 255 and zero flag bytes.
module binary_record_packer_unit import brp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  brp_req_t    req_item,
  output logic        res_valid,
  input  logic        res_stall,
  output brp_res_t    res_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  brp_cfg_t cfg;
  logic     q_full;
  logic     q_valid;
  logic     push;
  logic     pop;
  brp_cmd_t push_cmd;
  brp_cmd_t head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FLAG_BYTES) ? {28'b0, cfg.flag_bytes}
                                               : {24'b0, cfg.capacity};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity   <= 8'd255;
      cfg.flag_bytes <= 4'd0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_CAPACITY) begin
        cfg.capacity <= pwdata[7:0];
      end else begin
        cfg.flag_bytes <= pwdata[3:0];
      end
    end
  end

  brp_front u_front (
    .req_valid (req_valid),
    .req_item  (req_item),
    .q_full    (q_full),
    .req_stall (req_stall),
    .push      (push),
    .cmd       (push_cmd)
  );

  brp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  brp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

FILE: sv/brp_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, decodes the function code and builds a command.
// Depends on brp_pkg; feeds brp_queue.
module brp_front import brp_pkg::*; (
  input  logic     req_valid,
  input  brp_req_t req_item,
  input  logic     q_full,
  output logic     req_stall,
  output logic     push,
  output brp_cmd_t cmd
);

  localparam logic [31:0] HALF_RND  = 32'h0000_1000;
  localparam logic [15:0] HALF_SAT  = 16'h7FFF;
  localparam logic [23:0] SUB_BIAS  = 24'h7FF000;
  localparam logic [7:0]  EXP_BIAS  = 8'd112;
  localparam logic [7:0]  EXP_SUB   = 8'd101;
  localparam logic [7:0]  EXP_MAX   = 8'd143;
  localparam logic [7:0]  SUB_SHIFT = 8'd125;

  function automatic logic [15:0] to_half(input logic [31:0] x);
    logic [31:0] b;
    logic [7:0]  e;
    logic [22:0] m;
    logic [15:0] h;
    logic [23:0] s;
    logic [4:0]  sh;
    logic [23:0] q;
    logic [23:0] r;
    b = x + HALF_RND;
    e = b[30:23];
    m = b[22:0];
    h = {b[31], 15'b0};
    s = SUB_BIAS + {1'b0, m};
    sh = 5'(SUB_SHIFT - e);
    q = s >> sh;
    r = q + 24'd1;
    if (e > EXP_BIAS) begin
      h = h | {1'b0, 5'(e - EXP_BIAS), m[22:13]};
    end
    if (e <= EXP_BIAS && e > EXP_SUB) begin
      h = h | r[16:1];
    end
    if (e > EXP_MAX) begin
      h = h | HALF_SAT;
    end
    return h;
  endfunction

  logic known;

  assign req_stall = q_full;

  always_comb begin
    known      = 1'b1;
    cmd.op     = OP_BYTES;
    cmd.nbytes = 4'd1;
    cmd.data   = req_item.value;
    case (req_item.func)
      FUNC_BEGIN:  cmd.op = OP_BEGIN;
      FUNC_FLAG:   cmd.op = OP_FLAG;
      FUNC_INT8:   cmd.nbytes = 4'd1;
      FUNC_INT16:  cmd.nbytes = 4'd2;
      FUNC_INT24:  cmd.nbytes = 4'd3;
      FUNC_INT32:  cmd.nbytes = 4'd4;
      FUNC_INT64:  cmd.nbytes = 4'd8;
      FUNC_REAL16: begin
        cmd.nbytes = 4'd2;
        cmd.data   = {48'b0, to_half(req_item.value[31:0])};
      end
      FUNC_REAL32: cmd.nbytes = 4'd4;
      FUNC_REAL64: cmd.nbytes = 4'd8;
      FUNC_END:    cmd.op = OP_END;
      default:     known = 1'b0;
    endcase
  end

  assign push = req_valid && !q_full && known;

endmodule

FILE: sv/brp_queue.sv
`timescale 1ns / 1ps
// Command queue between the front end and the serializer.
// Depends on brp_pkg for the command type.
module brp_queue import brp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  brp_cmd_t push_cmd,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output brp_cmd_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  brp_cmd_t      entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: sv/brp_back.sv
`timescale 1ns / 1ps
// Serializer: runs queued commands, keeps record state, emits one byte per cycle when
// the output is not stalled. Depends on brp_pkg; drives the result output register.
module brp_back import brp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  brp_cfg_t cfg,
  input  logic     q_valid,
  input  brp_cmd_t q_cmd,
  output logic     pop,
  output logic     res_valid,
  input  logic     res_stall,
  output brp_res_t res_item
);

  logic        busy, busy_next;
  brp_op_t     op, op_next;
  logic [63:0] data, data_next;
  logic [3:0]  cnt, cnt_next;
  logic [7:0]  length_count, length_count_next;
  logic [63:0] flag_word, flag_word_next;
  logic [6:0]  flag_count, flag_count_next;
  logic        ok_flag, ok_flag_next;
  logic        res_valid_next;
  brp_res_t    res_item_next;

  logic        adv;
  logic        done;
  logic        fits;
  logic        near_full;
  logic [6:0]  max_flags;
  logic [3:0]  end_bytes;

  always_comb begin
    case (cfg.flag_bytes)
      4'd1:    end_bytes = 4'd1;
      4'd2:    end_bytes = 4'd2;
      4'd4:    end_bytes = 4'd4;
      4'd8:    end_bytes = 4'd8;
      default: end_bytes = 4'd0;
    endcase
  end

  assign adv       = !res_valid || !res_stall;
  assign max_flags = {cfg.flag_bytes, 3'b000};
  assign fits      = ({1'b0, length_count} + 9'd1) <= {1'b0, cfg.capacity};
  assign near_full = ({1'b0, length_count} + 9'd2) > {1'b0, cfg.capacity};

  always_comb begin
    busy_next         = busy;
    op_next           = op;
    data_next         = data;
    cnt_next          = cnt;
    length_count_next = length_count;
    flag_word_next    = flag_word;
    flag_count_next   = flag_count;
    ok_flag_next      = ok_flag;
    res_valid_next    = adv ? 1'b0 : res_valid;
    res_item_next     = res_item;
    done              = 1'b0;
    pop               = 1'b0;

    if (busy && adv) begin
      case (op)
        OP_BEGIN: begin
          length_count_next = '0;
          flag_word_next    = '0;
          flag_count_next   = '0;
          ok_flag_next      = 1'b1;
          done              = 1'b1;
        end
        OP_FLAG: begin
          if (flag_count >= max_flags) begin
            ok_flag_next = 1'b0;
          end else begin
            if (data[0] && !flag_count[6]) begin
              flag_word_next = flag_word | (64'd1 << flag_count[5:0]);
            end
            flag_count_next = flag_count + 7'd1;
          end
          done = 1'b1;
        end
        OP_BYTES, OP_END: begin
          if (cnt != 4'd0) begin
            if (fits) begin
              res_valid_next              = 1'b1;
              res_item_next.kind          = 1'b0;
              res_item_next.byte_value    = data[7:0];
              res_item_next.byte_index    = length_count;
              res_item_next.record_length = '0;
              res_item_next.success       = ok_flag;
              res_item_next.last          = (op == OP_BYTES) && (cnt == 4'd1 || near_full);
              length_count_next           = length_count + 8'd1;
              data_next                   = {8'b0, data[63:8]};
              cnt_next                    = cnt - 4'd1;
              done                        = (op == OP_BYTES) && (cnt == 4'd1);
            end else begin
              ok_flag_next = 1'b0;
              cnt_next     = '0;
              done         = (op == OP_BYTES);
            end
          end else begin
            res_valid_next              = 1'b1;
            res_item_next.kind          = 1'b1;
            res_item_next.byte_value    = '0;
            res_item_next.byte_index    = '0;
            res_item_next.record_length = ok_flag ? length_count : 8'd0;
            res_item_next.success       = ok_flag;
            res_item_next.last          = 1'b1;
            done                        = 1'b1;
          end
        end
        default: done = 1'b1;
      endcase
    end

    if (done) begin
      busy_next = 1'b0;
    end

    if (q_valid && (!busy || done)) begin
      pop       = 1'b1;
      busy_next = 1'b1;
      op_next   = q_cmd.op;
      if (q_cmd.op == OP_END) begin
        data_next = flag_word_next;
        cnt_next  = end_bytes;
      end else begin
        data_next = q_cmd.data;
        cnt_next  = q_cmd.nbytes;
      end
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    data     <= data_next;
    cnt      <= cnt_next;
    res_item <= res_item_next;
    if (rst) begin
      busy         <= 1'b0;
      length_count <= '0;
      flag_word    <= '0;
      flag_count   <= '0;
      ok_flag      <= 1'b1;
      res_valid    <= 1'b0;
    end else begin
      busy         <= busy_next;
      length_count <= length_count_next;
      flag_word    <= flag_word_next;
      flag_count   <= flag_count_next;
      ok_flag      <= ok_flag_next;
      res_valid    <= res_valid_next;
    end
  end

endmodule

FILE: sv/brp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the binary record packer, bound to the top level.
// Depends on brp_pkg for the result type.
module brp_checker import brp_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     res_valid,
  input logic     res_stall,
  input brp_res_t res_item
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("result changed while stalled");

  a_done_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.kind |->
      res_item.last && res_item.byte_value == 8'd0 && res_item.byte_index == 8'd0)
    else $error("malformed completion");

  a_fail_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.kind && !res_item.success |-> res_item.record_length == 8'd0)
    else $error("failed record reports a length");

  a_data_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.kind |->
      res_item.record_length == 8'd0 && res_item.byte_index != 8'd255)
    else $error("malformed data byte");

endmodule

bind binary_record_packer_unit brp_checker u_brp_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);
